@@ hw/rtl/epx_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the color compare for the epx pixel doubler
// no dependencies; every other file of the block uses this package

package epx_pkg;

    // fixed field widths
    localparam int PIX_W     = 32;
    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // defaults for the top-level parameters
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 1024;

    // register values after reset
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    // only r, g and b take part in the compare
    localparam logic [PIX_W-1:0] RGB_MASK = 32'h00FF_FFFF;

    // input word kinds
    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // per-word control from the sequencer to the datapath
    typedef struct packed
    {
        logic emit;      // word produces a block
        logic up_ok;     // up neighbor lies inside the frame
        logic left_ok;   // left neighbor lies inside the frame
        logic right_ok;  // right neighbor lies inside the frame
        logic down_pix;  // down neighbor is the incoming pixel (else the center)
        logic done;      // last block of the frame
    } flags_t;

    function automatic logic same_rgb(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
        return ((a ^ b) & RGB_MASK) == '0;
    endfunction

endpackage

@@ hw/rtl/epx_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces: source pixels in, doubled 2x2 blocks out
// depends on epx_pkg

interface epx_pixel_if;
    logic                       valid;
    logic                       ready;
    epx_pkg::op_t               op;
    logic [epx_pkg::PIX_W-1:0]  pixel_rgba;

    modport source (output valid, op, pixel_rgba, input ready);
    modport sink   (input valid, op, pixel_rgba, output ready);
endinterface

interface epx_block_if;
    logic                         valid;
    logic                         ready;
    logic [epx_pkg::COORD_W-1:0]  block_x;
    logic [epx_pkg::COORD_W-1:0]  block_y;
    logic [epx_pkg::PIX_W-1:0]    sub_up_left;
    logic [epx_pkg::PIX_W-1:0]    sub_up_right;
    logic [epx_pkg::PIX_W-1:0]    sub_down_left;
    logic [epx_pkg::PIX_W-1:0]    sub_down_right;
    logic                         frame_done;

    modport source (output valid, block_x, block_y, sub_up_left, sub_up_right,
                    sub_down_left, sub_down_right, frame_done, input ready);
    modport sink   (input valid, block_x, block_y, sub_up_left, sub_up_right,
                    sub_down_left, sub_down_right, frame_done, output ready);
endinterface

@@ hw/rtl/epx_ctrl.sv @@
`timescale 1ns / 1ps
// frame sequencer: configuration registers, column/row/drain counters,
// per-word control flags and line store addressing; depends on epx_pkg

module epx_ctrl #(
    parameter int MAX_WIDTH  = epx_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = epx_pkg::DEFAULT_MAX_HEIGHT,
    localparam int AW  = $clog2(MAX_WIDTH),
    localparam int HAW = $clog2(MAX_HEIGHT)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [epx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [epx_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          accept,
    input  epx_pkg::op_t                  op,
    output epx_pkg::flags_t               req,
    output logic [AW-1:0]                 x,
    output logic [HAW-1:0]                y,
    output logic                          newer_we
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int W_RST = (epx_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                           MAX_WIDTH : epx_pkg::FRAME_WIDTH_RST;
    localparam int H_RST = (epx_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                           MAX_HEIGHT : epx_pkg::FRAME_HEIGHT_RST;

    logic [WW-1:0]  width_reg, width_next;
    logic [HW-1:0]  height_reg, height_next;
    logic [AW-1:0]  col_reg, col_next;
    logic [HAW-1:0] row_reg, row_next;
    logic [AW-1:0]  drain_reg, drain_next;
    logic           draining_reg, draining_next;

    logic [WW-1:0]  width_clamp;
    logic [HW-1:0]  height_clamp;
    logic [WW-1:0]  x_inc;
    logic [HW-1:0]  row_inc;
    logic           col_last;
    logic           pixel_ok;
    logic           drain_ok;

    // zero acts as one, anything above the maximum as the maximum
    always_comb
    begin
        if (cfg_data == '0)
            width_clamp = WW'(1);
        else if (32'(cfg_data) > MAX_WIDTH)
            width_clamp = WW'(MAX_WIDTH);
        else
            width_clamp = WW'(cfg_data);

        if (cfg_data == '0)
            height_clamp = HW'(1);
        else if (32'(cfg_data) > MAX_HEIGHT)
            height_clamp = HW'(MAX_HEIGHT);
        else
            height_clamp = HW'(cfg_data);
    end

    // current word position and flags
    assign pixel_ok = (op == epx_pkg::OP_PIXEL) && !draining_reg;
    assign drain_ok = (op == epx_pkg::OP_DRAIN) && draining_reg;
    assign x        = draining_reg ? drain_reg : col_reg;
    assign y        = draining_reg ? row_reg : row_reg - HAW'(1);
    assign x_inc    = WW'(x) + WW'(1);
    assign row_inc  = HW'(row_reg) + HW'(1);
    assign col_last = (x_inc == width_reg);
    assign newer_we = accept && pixel_ok;

    always_comb
    begin
        req.emit     = (pixel_ok && (row_reg != '0)) || drain_ok;
        req.up_ok    = (y != '0);
        req.left_ok  = (x != '0);
        req.right_ok = !col_last;
        req.down_pix = !draining_reg;
        req.done     = drain_ok && col_last;
    end

    // counter and register updates
    always_comb
    begin
        logic restart;
        restart       = 1'b0;
        width_next    = width_reg;
        height_next   = height_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        drain_next    = drain_reg;
        draining_next = draining_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                epx_pkg::REG_FRAME_WIDTH:
                begin
                    width_next = width_clamp;
                    restart    = 1'b1;
                end
                epx_pkg::REG_FRAME_HEIGHT:
                begin
                    height_next = height_clamp;
                    restart     = 1'b1;
                end
                default: ;
            endcase
        end
        else if (accept)
        begin
            if (pixel_ok)
            begin
                if (col_last)
                begin
                    col_next = '0;
                    if (row_inc == height_reg)
                    begin
                        draining_next = 1'b1;
                        drain_next    = '0;
                    end
                    else
                    begin
                        row_next = row_reg + HAW'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + AW'(1);
                end
            end
            else if (drain_ok)
            begin
                if (col_last)
                    restart = 1'b1;
                else
                    drain_next = drain_reg + AW'(1);
            end
        end

        if (restart)
        begin
            col_next      = '0;
            row_next      = '0;
            drain_next    = '0;
            draining_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WW'(W_RST);
            height_reg   <= HW'(H_RST);
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            drain_reg    <= drain_next;
            draining_reg <= draining_next;
        end
    end

endmodule

@@ hw/rtl/epx_line_store.sv @@
`timescale 1ns / 1ps
// two line memories (newer row, older row) with registered reads
// and a bypass for an older-row write that lands on the address being read

module epx_line_store #(
    parameter int MAX_WIDTH = epx_pkg::DEFAULT_MAX_WIDTH,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    input  logic                      newer_we,
    input  logic [epx_pkg::PIX_W-1:0] newer_wdata,
    input  logic                      older_we,
    input  logic [AW-1:0]             older_waddr,
    input  logic [epx_pkg::PIX_W-1:0] older_wdata,
    output logic [epx_pkg::PIX_W-1:0] center,
    output logic [epx_pkg::PIX_W-1:0] right,
    output logic [epx_pkg::PIX_W-1:0] up
);

    logic [epx_pkg::PIX_W-1:0] newer_mem [MAX_WIDTH];
    logic [epx_pkg::PIX_W-1:0] older_mem [MAX_WIDTH];

    logic [epx_pkg::PIX_W-1:0] center_reg;
    logic [epx_pkg::PIX_W-1:0] right_reg;
    logic [epx_pkg::PIX_W-1:0] up_reg;
    logic [epx_pkg::PIX_W-1:0] fwd_data_reg;
    logic                      fwd_hit_reg;
    logic [AW-1:0]             right_addr;

    // right neighbor address, kept inside the array at the last column
    assign right_addr = (rd_addr == AW'(MAX_WIDTH - 1)) ? '0 : rd_addr + AW'(1);

    // newer row: write the incoming pixel, read center and right (old data)
    always_ff @(posedge clk)
    begin
        if (newer_we)
            newer_mem[rd_addr] <= newer_wdata;
        if (rd_en)
        begin
            center_reg <= newer_mem[rd_addr];
            right_reg  <= newer_mem[right_addr];
        end
    end

    // older row: write back the retired center, read the up neighbor
    always_ff @(posedge clk)
    begin
        if (older_we)
            older_mem[older_waddr] <= older_wdata;
        if (rd_en)
            up_reg <= older_mem[rd_addr];
        if (older_we)
            fwd_data_reg <= older_wdata;
    end

    // bypass when the write and the read hit the same entry on the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else if (rd_en)
            fwd_hit_reg <= older_we && (older_waddr == rd_addr);
    end

    assign center = center_reg;
    assign right  = right_reg;
    assign up     = fwd_hit_reg ? fwd_data_reg : up_reg;

endmodule

@@ hw/rtl/epx_rule.sv @@
`timescale 1ns / 1ps
// epx corner rule: border replacement of the four neighbors and the choice
// of each sub-pixel; depends on epx_pkg

module epx_rule (
    input  epx_pkg::flags_t           flags,
    input  logic [epx_pkg::PIX_W-1:0] center,
    input  logic [epx_pkg::PIX_W-1:0] up_raw,
    input  logic [epx_pkg::PIX_W-1:0] left_raw,
    input  logic [epx_pkg::PIX_W-1:0] right_raw,
    input  logic [epx_pkg::PIX_W-1:0] pixel,
    output logic [epx_pkg::PIX_W-1:0] sub_ul,
    output logic [epx_pkg::PIX_W-1:0] sub_ur,
    output logic [epx_pkg::PIX_W-1:0] sub_dl,
    output logic [epx_pkg::PIX_W-1:0] sub_dr
);

    logic [epx_pkg::PIX_W-1:0] up, left, right, down;
    logic u_l, u_r, d_l, d_r, u_d, flat;

    // neighbors outside the frame take the center
    assign up    = flags.up_ok    ? up_raw    : center;
    assign left  = flags.left_ok  ? left_raw  : center;
    assign right = flags.right_ok ? right_raw : center;
    assign down  = flags.down_pix ? pixel     : center;

    // rgb compares
    assign u_l = epx_pkg::same_rgb(up, left);
    assign u_r = epx_pkg::same_rgb(up, right);
    assign d_l = epx_pkg::same_rgb(down, left);
    assign d_r = epx_pkg::same_rgb(down, right);
    assign u_d = epx_pkg::same_rgb(up, down);

    // three equal neighbors keep the whole block at the center color
    assign flat = (u_l && u_r) || (u_l && u_d) || (u_r && u_d) || (d_l && d_r);

    assign sub_ul = (u_l && !flat) ? up   : center;
    assign sub_ur = (u_r && !flat) ? up   : center;
    assign sub_dl = (d_l && !flat) ? down : center;
    assign sub_dr = (d_r && !flat) ? down : center;

endmodule

@@ hw/rtl/epx_pixel_doubler_top.sv @@
`timescale 1ns / 1ps
// top level of the epx pixel doubler: sequencer, line stores, rule and
// output register; depends on epx_pkg, epx_if and the epx_* submodules
//
//  channel   dir  handshake     word
//  pixels    in   valid/ready   op, pixel_rgba
//  blocks    out  valid/ready   block_x, block_y, 4 sub-pixels, frame_done
//  cfg       in   cfg_wr_en     cfg_index, cfg_data (no read-back)
//
// one input word per clock while the output is not stalled; a block leaves
// through the line store read and then the output register
// line store reads set the rate: newer row twice, older row once per word
// reset clears counters and valid flags and loads the default frame size;
// the line stores are not cleared
// a stalled output holds the read stage, and input ready drops while both
// the read stage and the output register are full and the output stalls

module epx_pixel_doubler_top #(
    parameter int MAX_WIDTH  = epx_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = epx_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    epx_pixel_if.sink                     pixels,
    epx_block_if.source                   blocks,
    input  logic                          cfg_wr_en,
    input  logic [epx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [epx_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int HAW = $clog2(MAX_HEIGHT);

    epx_pkg::flags_t           req_flags;
    logic [AW-1:0]             req_x;
    logic [HAW-1:0]            req_y;
    logic                      newer_we;
    logic                      acc;
    logic                      b_move;
    logic                      older_we;

    logic                      b_valid_reg;
    epx_pkg::flags_t           b_flags_reg;
    logic [AW-1:0]             b_x_reg;
    logic [HAW-1:0]            b_y_reg;
    logic [epx_pkg::PIX_W-1:0] b_pix_reg;
    logic [epx_pkg::PIX_W-1:0] left_reg;

    logic [epx_pkg::PIX_W-1:0] center, right, up;
    logic [epx_pkg::PIX_W-1:0] sub_ul, sub_ur, sub_dl, sub_dr;
    logic [31:0]               bx32, by32;

    logic                          out_valid_reg, out_valid_next;
    logic [epx_pkg::COORD_W-1:0]   out_x_reg, out_y_reg;
    logic [epx_pkg::PIX_W-1:0]     out_ul_reg, out_ur_reg, out_dl_reg, out_dr_reg;
    logic                          out_done_reg;

    // handshake
    assign b_move       = b_valid_reg && (!out_valid_reg || blocks.ready);
    assign pixels.ready = !b_valid_reg || b_move;
    assign acc          = pixels.valid && pixels.ready;

    epx_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (acc),
        .op        (pixels.op),
        .req       (req_flags),
        .x         (req_x),
        .y         (req_y),
        .newer_we  (newer_we)
    );

    // retired center goes back to the older row
    assign older_we = b_move && b_flags_reg.down_pix;

    epx_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (acc),
        .rd_addr     (req_x),
        .newer_we    (newer_we),
        .newer_wdata (pixels.pixel_rgba),
        .older_we    (older_we),
        .older_waddr (b_x_reg),
        .older_wdata (center),
        .center      (center),
        .right       (right),
        .up          (up)
    );

    // read stage control, valid while memory data is pending
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (acc)
            b_valid_reg <= req_flags.emit;
        else if (b_move)
            b_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            b_flags_reg <= req_flags;
            b_x_reg     <= req_x;
            b_y_reg     <= req_y;
            b_pix_reg   <= pixels.pixel_rgba;
        end
        if (b_move)
            left_reg <= center;
    end

    epx_rule u_rule (
        .flags     (b_flags_reg),
        .center    (center),
        .up_raw    (up),
        .left_raw  (left_reg),
        .right_raw (right),
        .pixel     (b_pix_reg),
        .sub_ul    (sub_ul),
        .sub_ur    (sub_ur),
        .sub_dl    (sub_dl),
        .sub_dr    (sub_dr)
    );

    // output register
    assign bx32 = 32'(b_x_reg);
    assign by32 = 32'(b_y_reg);

    always_comb
    begin
        if (b_move)
            out_valid_next = 1'b1;
        else if (blocks.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_move)
        begin
            out_x_reg    <= bx32[epx_pkg::COORD_W-1:0];
            out_y_reg    <= by32[epx_pkg::COORD_W-1:0];
            out_ul_reg   <= sub_ul;
            out_ur_reg   <= sub_ur;
            out_dl_reg   <= sub_dl;
            out_dr_reg   <= sub_dr;
            out_done_reg <= b_flags_reg.done;
        end
    end

    assign blocks.valid          = out_valid_reg;
    assign blocks.block_x        = out_x_reg;
    assign blocks.block_y        = out_y_reg;
    assign blocks.sub_up_left    = out_ul_reg;
    assign blocks.sub_up_right   = out_ur_reg;
    assign blocks.sub_down_left  = out_dl_reg;
    assign blocks.sub_down_right = out_dr_reg;
    assign blocks.frame_done     = out_done_reg;

    // a held read stage keeps its word and blocks new reads
    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !b_move |=> b_valid_reg && $stable(b_x_reg))
        else $error("read stage lost its word while stalled");

    a_no_read_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !b_move |-> !acc)
        else $error("line store read while read stage is held");

    a_emit_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
        acc && req_flags.emit |=> b_valid_reg)
        else $error("emitting word did not reach the read stage");

endmodule
